// ===== rtl/tlfq_pkg.sv =====
package tlfq_pkg;

  localparam int ID_W  = 4;
  localparam int ID_N  = 2 ** ID_W;
  localparam int LEN_W = 16;
  localparam int QNT_W = 8;
  localparam int LVL_W = 2;
  localparam int APB_W = 32;
  localparam int ADDR_W = 3;

  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [LVL_W-1:0] LVL_0 = 2'd0;
  localparam logic [LVL_W-1:0] LVL_1 = 2'd1;
  localparam logic [LVL_W-1:0] LVL_2 = 2'd2;

  // register select, taken from paddr[2]
  localparam logic REG_QUANTUM0 = 1'b0;
  localparam logic REG_QUANTUM1 = 1'b1;

  localparam logic [QNT_W-1:0] QUANTUM0_RESET = 8'd2;
  localparam logic [QNT_W-1:0] QUANTUM1_RESET = 8'd4;

  typedef struct packed {
    logic [QNT_W-1:0] level1;
    logic [QNT_W-1:0] level0;
  } quanta_t;

  typedef struct packed {
    logic             demoted;
    logic             finished;
    logic [LVL_W-1:0] level;
    logic [ID_W-1:0]  task_id;
  } result_t;

endpackage

// ===== rtl/tlfq_cfg.sv =====
module tlfq_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         reg_sel,
  input  logic [tlfq_pkg::APB_W-1:0]   pwdata,
  output logic [tlfq_pkg::APB_W-1:0]   prdata,
  output tlfq_pkg::quanta_t            quanta
);
  import tlfq_pkg::*;

  logic wr_en;

  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      quanta.level0 <= QUANTUM0_RESET;
      quanta.level1 <= QUANTUM1_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_QUANTUM0: quanta.level0 <= pwdata[QNT_W-1:0];
        REG_QUANTUM1: quanta.level1 <= pwdata[QNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_QUANTUM0: prdata = APB_W'(quanta.level0);
      REG_QUANTUM1: prdata = APB_W'(quanta.level1);
      default:      prdata = '0;
    endcase
  end

endmodule

// ===== rtl/tlfq_queue.sv =====
module tlfq_queue #(
  parameter int DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic [tlfq_pkg::ID_W-1:0]     push_id,
  input  logic                          pop,
  output logic [tlfq_pkg::ID_W-1:0]     head_id,
  output logic [$clog2(DEPTH+1)-1:0]    count
);
  import tlfq_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [ID_W-1:0] mem [DEPTH];
  logic [IW-1:0]   head;
  logic [IW-1:0]   head_next;
  logic [IW:0]     tail_sum;
  logic [IW-1:0]   tail;

  // head + count never reaches twice the depth
  assign tail_sum  = (IW + 1)'(head) + (IW + 1)'(count);
  assign tail      = (tail_sum >= (IW + 1)'(DEPTH)) ? IW'(tail_sum - (IW + 1)'(DEPTH))
                                                    : IW'(tail_sum);
  assign head_next = (head == IW'(DEPTH - 1)) ? '0 : head + IW'(1);
  assign head_id   = mem[head];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= push_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      if (pop) begin
        head <= head_next;
      end
      unique case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/three_level_feedback_queue_scheduler_core.sv =====
// Three-level feedback queue scheduler.
// Input stream s_*: s_tuser is the operation (0 arrival, 1 tick); s_tdata
// carries the task id and its work length. Arrivals join the tail of level 0
// and give no result; a tick runs the head of the highest busy level for one
// unit and gives one result on m_*: m_tuser is 1 when a task ran, 0 when
// idle, and m_tdata then says which task, from which level, and whether it
// finished or dropped a level.
// APB port: quantum_level0 at 0x0, quantum_level1 at 0x4, to be written by the user
// only while the block is idle, which the block does not enforce; pready is tied high.
// Timing: one item is accepted per cycle. An item is held in the input
// register, then the queue-head lookup, the remaining-work lookup and all
// state updates happen in one pass, and the tick result lands in the output
// register, which raises m_tvalid. When m_tready is low with a result held,
// ticks wait in the input register and s_tready drops; arrivals still pass.
// Reset clears queue heads, counts, quantum counters and both valid flags;
// queue and work stores hold undefined values until written.
module three_level_feedback_queue_scheduler_core #(
  parameter int MAX_TASKS   = 16,
  parameter int QUEUE_DEPTH = 16,
  parameter int WORK_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [23:0]                   s_tdata,  // task_id[3:0], work_length[19:4], zeros
  input  logic [0:0]                    s_tuser,  // operation
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,  // running_task[3:0], run_level[5:4],
                                                  // task_finished[6], task_demoted[7]
  output logic [0:0]                    m_tuser,  // ran_valid
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tlfq_pkg::ADDR_W-1:0]   paddr,
  input  logic [tlfq_pkg::APB_W-1:0]    pwdata,
  output logic [tlfq_pkg::APB_W-1:0]    prdata,
  output logic                          pready
);
  import tlfq_pkg::*;

  localparam int SLOT_W = $clog2(MAX_TASKS);
  localparam int CW     = $clog2(QUEUE_DEPTH + 1);

  quanta_t quanta;

  assign pready = 1'b1;

  tlfq_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .reg_sel (paddr[2]),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .quanta  (quanta)
  );

  // input register
  logic             in_valid;
  logic             in_op;
  logic [ID_W-1:0]  in_id;
  logic [LEN_W-1:0] in_len;

  logic out_free;
  logic arr_fire;
  logic tick_fire;
  logic proc_fire;

  assign out_free  = !m_tvalid || m_tready;
  assign arr_fire  = in_valid && (in_op == OP_ARRIVE);
  assign tick_fire = in_valid && (in_op == OP_TICK) && out_free;
  assign proc_fire = arr_fire || tick_fire;
  assign s_tready  = !in_valid || proc_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op  <= s_tuser[0];
      in_id  <= s_tdata[ID_W-1:0];
      in_len <= s_tdata[ID_W+LEN_W-1:ID_W];
    end
  end

  // task id to work slot, folded at elaboration
  logic [SLOT_W-1:0] slot_lut [ID_N];
  for (genvar g = 0; g < ID_N; g++) begin : g_slot
    assign slot_lut[g] = SLOT_W'(g % MAX_TASKS);
  end

  // queues
  logic [2:0]      push;
  logic [2:0]      pop;
  logic [ID_W-1:0] push_id [3];
  logic [ID_W-1:0] head_id [3];
  logic [CW-1:0]   cnt     [3];

  for (genvar l = 0; l < 3; l++) begin : g_lvl
    tlfq_queue #(
      .DEPTH (QUEUE_DEPTH)
    ) u_queue (
      .clk     (clk),
      .rst     (rst),
      .push    (push[l]),
      .push_id (push_id[l]),
      .pop     (pop[l]),
      .head_id (head_id[l]),
      .count   (cnt[l])
    );
  end

  logic [WORK_BITS-1:0] rem_work [MAX_TASKS];
  logic [QNT_W-1:0]     used0;
  logic [QNT_W-1:0]     used1;
  logic [QNT_W-1:0]     used0_next;
  logic [QNT_W-1:0]     used1_next;

  logic [WORK_BITS-1:0] in_work;
  logic                 has_run;
  logic [LVL_W-1:0]     run_lvl;
  logic [ID_W-1:0]      run_id;
  logic [SLOT_W-1:0]    run_slot;
  logic [WORK_BITS-1:0] run_work;
  logic                 finished;
  logic                 demoted;
  logic [QNT_W-1:0]     quantum;
  logic [QNT_W-1:0]     used_cur;
  logic [QNT_W:0]       used_inc;
  logic                 expired;
  logic                 next_full;
  logic                 rem_we;
  logic [SLOT_W-1:0]    rem_waddr;
  logic [WORK_BITS-1:0] rem_wdata;
  result_t              res_next;

  assign in_work    = WORK_BITS'(in_len);
  assign push_id[0] = in_id;
  assign push_id[1] = run_id;
  assign push_id[2] = run_id;

  always_comb begin
    has_run = 1'b1;
    priority if (cnt[0] != '0) begin
      run_lvl = LVL_0;
    end else if (cnt[1] != '0) begin
      run_lvl = LVL_1;
    end else if (cnt[2] != '0) begin
      run_lvl = LVL_2;
    end else begin
      run_lvl = LVL_0;
      has_run = 1'b0;
    end

    unique case (run_lvl)
      LVL_0: begin
        run_id    = head_id[0];
        quantum   = quanta.level0;
        used_cur  = used0;
        next_full = (cnt[1] == CW'(QUEUE_DEPTH));
      end
      LVL_1: begin
        run_id    = head_id[1];
        quantum   = quanta.level1;
        used_cur  = used1;
        next_full = (cnt[2] == CW'(QUEUE_DEPTH));
      end
      default: begin
        run_id    = head_id[2];
        quantum   = quanta.level1;
        used_cur  = used1;
        next_full = 1'b1;
      end
    endcase

    run_slot = slot_lut[run_id];
    run_work = rem_work[run_slot];
    finished = (run_work == '0) || (run_work == WORK_BITS'(1));
    // a quantum of zero behaves as one: used_inc is never below one
    used_inc = (QNT_W + 1)'(used_cur) + (QNT_W + 1)'(1);
    expired  = (used_inc >= (QNT_W + 1)'(quantum));

    push       = '0;
    pop        = '0;
    rem_we     = 1'b0;
    rem_waddr  = run_slot;
    rem_wdata  = run_work - WORK_BITS'(1);
    used0_next = used0;
    used1_next = used1;
    demoted    = 1'b0;

    if (arr_fire) begin
      if ((in_work != '0) && (cnt[0] != CW'(QUEUE_DEPTH))) begin
        push[0]   = 1'b1;
        rem_we    = 1'b1;
        rem_waddr = slot_lut[in_id];
        rem_wdata = in_work;
      end
    end else if (tick_fire && has_run) begin
      rem_we = 1'b1;
      if (finished) begin
        rem_wdata    = '0;
        pop[run_lvl] = 1'b1;
        if (run_lvl == LVL_0) used0_next = '0;
        if (run_lvl == LVL_1) used1_next = '0;
      end else if (run_lvl != LVL_2) begin
        if (expired) begin
          if (run_lvl == LVL_0) used0_next = '0;
          else                  used1_next = '0;
          // with the next level full the task keeps its place
          if (!next_full) begin
            push[run_lvl + LVL_W'(1)] = 1'b1;
            pop[run_lvl]              = 1'b1;
            demoted                   = 1'b1;
          end
        end else begin
          if (run_lvl == LVL_0) used0_next = used_inc[QNT_W-1:0];
          else                  used1_next = used_inc[QNT_W-1:0];
        end
      end
    end

    res_next.task_id  = has_run ? run_id : '0;
    res_next.level    = has_run ? run_lvl : LVL_0;
    res_next.finished = has_run && finished;
    res_next.demoted  = demoted;
  end

  always_ff @(posedge clk) begin
    if (rem_we) begin
      rem_work[rem_waddr] <= rem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used0 <= '0;
      used1 <= '0;
    end else begin
      used0 <= used0_next;
      used1 <= used1_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (tick_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      m_tdata    <= res_next;
      m_tuser[0] <= has_run;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("idle result carries non-zero fields");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[6] && m_tdata[7]))
    else $error("task both finished and demoted");

  assert property (@(posedge clk) disable iff (rst)
    tick_fire |=> m_tvalid)
    else $error("tick transaction lost its result");

  assert property (@(posedge clk) disable iff (rst)
    (cnt[0] <= CW'(QUEUE_DEPTH)) && (cnt[1] <= CW'(QUEUE_DEPTH)) &&
    (cnt[2] <= CW'(QUEUE_DEPTH)))
    else $error("queue count beyond depth");

endmodule

// ===== tb/tb_three_level_feedback_queue_scheduler_core.sv =====
module tb_three_level_feedback_queue_scheduler_core;
  timeunit 1ns;
  timeprecision 1ps;

  import tlfq_pkg::*;

  typedef struct packed {
    logic    ran;
    result_t r;
  } tick_report_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [23:0]       s_tdata = '0;   // task_id[3:0], work_length[19:4], zeros
  logic [0:0]        s_tuser = '0;   // operation
  logic              m_tvalid;
  logic              m_tready = 1'b1;
  logic [7:0]        m_tdata;        // running_task[3:0], run_level[5:4],
                                     // task_finished[6], task_demoted[7]
  logic [0:0]        m_tuser;        // ran_valid
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [APB_W-1:0]  pwdata = '0;
  logic [APB_W-1:0]  prdata;
  logic              pready;

  three_level_feedback_queue_scheduler_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // scheduler mirror
  logic [ID_W-1:0]  level_fifo [3][16];
  int unsigned      fifo_head [3];
  int unsigned      fifo_count [3];
  logic [LEN_W-1:0] work_left [ID_N];
  int unsigned      level_used [2];
  logic [QNT_W-1:0] quanta [2];
  int               live_refs [ID_N];

  tick_report_t     reports_due [$];
  tick_report_t     due_head;
  tick_report_t     seen;
  int               mismatches = 0;
  bit               src_stalls = 1'b1;
  bit               sink_stalls = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_three_level_feedback_queue_scheduler_core: FAIL");
    $finish;
  end

  function automatic bit fifo_push(input int lv, input logic [ID_W-1:0] id);
    if (fifo_count[lv] >= 16) return 1'b0;
    level_fifo[lv][(fifo_head[lv] + fifo_count[lv]) % 16] = id;
    fifo_count[lv]++;
    live_refs[id]++;
    return 1'b1;
  endfunction

  function automatic void fifo_pop(input int lv);
    live_refs[level_fifo[lv][fifo_head[lv]]]--;
    fifo_head[lv] = (fifo_head[lv] + 1) % 16;
    fifo_count[lv]--;
  endfunction

  function automatic int queued_total();
    return fifo_count[0] + fifo_count[1] + fifo_count[2];
  endfunction

  function automatic void schedule_step(input logic op, input logic [ID_W-1:0] id,
                                        input logic [LEN_W-1:0] len);
    tick_report_t     rep;
    int               lv;
    logic [ID_W-1:0]  run_id;
    bit               fin;
    bit               dem;
    if (op == OP_ARRIVE) begin
      if (len != '0 && fifo_push(0, id)) work_left[id] = len;
      return;
    end
    rep = '0;
    lv = 0;
    while (lv < 3 && fifo_count[lv] == 0) lv++;
    if (lv == 3) begin
      reports_due.push_back(rep);
      return;
    end
    run_id = level_fifo[lv][fifo_head[lv]];
    fin = 1'b0;
    dem = 1'b0;
    if (work_left[run_id] > 1) begin
      work_left[run_id]--;
    end else begin
      work_left[run_id] = '0;
      fin = 1'b1;
    end
    if (fin) begin
      fifo_pop(lv);
      if (lv < 2) level_used[lv] = 0;
    end else if (lv < 2) begin
      level_used[lv]++;
      if (level_used[lv] >= quanta[lv]) begin
        level_used[lv] = 0;
        // next level full: task keeps its place, count restarts
        if (fifo_push(lv + 1, run_id)) begin
          fifo_pop(lv);
          dem = 1'b1;
        end
      end
    end
    rep.ran        = 1'b1;
    rep.r.task_id  = run_id;
    rep.r.level    = LVL_W'(lv);
    rep.r.finished = fin;
    rep.r.demoted  = dem;
    reports_due.push_back(rep);
  endfunction

  always @(posedge clk) begin
    m_tready <= (sink_stalls && $urandom_range(99) < 37) ? 1'b0 : 1'b1;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen.ran = m_tuser[0];
      seen.r   = result_t'(m_tdata);
      if (reports_due.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected tick result: ran=%0d task=%0d lvl=%0d fin=%0d dem=%0d",
                   seen.ran, seen.r.task_id, seen.r.level, seen.r.finished,
                   seen.r.demoted);
        mismatches++;
      end else begin
        due_head = reports_due.pop_front();
        if (seen.ran !== due_head.ran || seen.r.task_id !== due_head.r.task_id ||
            seen.r.level !== due_head.r.level ||
            seen.r.finished !== due_head.r.finished ||
            seen.r.demoted !== due_head.r.demoted) begin
          if (mismatches < 10)
            $display("tick result mismatch: expected ran=%0d task=%0d lvl=%0d fin=%0d dem=%0d, got ran=%0d task=%0d lvl=%0d fin=%0d dem=%0d",
                     due_head.ran, due_head.r.task_id, due_head.r.level,
                     due_head.r.finished, due_head.r.demoted, seen.ran, seen.r.task_id,
                     seen.r.level, seen.r.finished, seen.r.demoted);
          mismatches++;
        end
      end
    end
  end

  task automatic offer_item(input logic op, input logic [ID_W-1:0] id,
                            input logic [LEN_W-1:0] len);
    while (src_stalls && $urandom_range(99) < 37) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0000, len, id};
    do @(posedge clk); while (!s_tready);
    schedule_step(op, id, len);
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_quantum(input logic sel, input logic [QNT_W-1:0] val);
    logic [APB_W-1:0] word;
    word = $urandom();
    word[QNT_W-1:0] = val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    quanta[sel] = val;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_quanta(input logic [QNT_W-1:0] q0, input logic [QNT_W-1:0] q1);
    wait_for_results();
    // trailing arrivals may still be in the pipe
    repeat (8) @(posedge clk);
    write_quantum(REG_QUANTUM0, q0);
    write_quantum(REG_QUANTUM1, q1);
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    logic [ID_W-1:0] free_ids [$];
    if ($urandom_range(99) < 85) begin
      for (int i = 0; i < ID_N; i++)
        if (live_refs[i] == 0) free_ids.push_back(ID_W'(i));
      if (free_ids.size() != 0) return free_ids[$urandom_range(free_ids.size() - 1)];
    end
    return ID_W'($urandom_range(ID_N - 1));
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 70) return LEN_W'($urandom_range(8, 1));
    if (r < 98) return LEN_W'($urandom_range(300, 9));
    return LEN_W'($urandom());
  endfunction

  task automatic run_random_items(input int n, input int tick_pct, input int pause_at);
    logic op;
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) wait_for_results();
      op = ($urandom_range(99) < tick_pct) ? OP_TICK : OP_ARRIVE;
      offer_item(op, pick_id(), pick_len());
    end
  endtask

  task automatic test_directed_basics();
    offer_item(OP_TICK, 4'd0, 16'h0000);       // idle from reset
    offer_item(OP_ARRIVE, 4'd4, 16'h0000);     // zero work, dropped
    offer_item(OP_TICK, 4'd15, 16'hFFFF);      // still idle
    offer_item(OP_ARRIVE, 4'd15, 16'hFFFF);
    offer_item(OP_ARRIVE, 4'd0, 16'h0001);
    offer_item(OP_TICK, 4'd0, 16'h0000);
    offer_item(OP_TICK, 4'd0, 16'h0000);       // 15 demoted to level 1
    offer_item(OP_TICK, 4'd0, 16'h0000);       // 0 finishes
    offer_item(OP_TICK, 4'd0, 16'h0000);       // 15 at level 1
    offer_item(OP_ARRIVE, 4'd5, 16'h0002);     // preempts level 1
    offer_item(OP_TICK, 4'd0, 16'h0000);
    offer_item(OP_TICK, 4'd0, 16'h0000);
    offer_item(OP_TICK, 4'd0, 16'h0000);       // level 1 count carried on
    offer_item(OP_ARRIVE, 4'd15, 16'h0001);    // live id again: work overwritten
    offer_item(OP_TICK, 4'd0, 16'h0000);
    offer_item(OP_TICK, 4'd0, 16'h0000);       // stale level 1 copy, no work left
    offer_item(OP_TICK, 4'd0, 16'h0000);
    offer_item(OP_ARRIVE, 4'd9, 16'h0003);
    offer_item(OP_TICK, 4'd0, 16'h0000);
    offer_item(OP_TICK, 4'd0, 16'h0000);
    offer_item(OP_TICK, 4'd0, 16'h0000);
    offer_item(OP_TICK, 4'd0, 16'h0000);
  endtask

  task automatic test_full_levels();
    int guard;
    guard = 0;
    while (queued_total() != 0 && guard < 400) begin
      offer_item(OP_TICK, pick_id(), pick_len());
      guard++;
    end
    set_quanta(8'd1, 8'd1);
    for (int i = 0; i < 17; i++)               // last one hits a full level 0
      offer_item(OP_ARRIVE, ID_W'(i), LEN_W'($urandom_range(60, 20)));
    repeat (32) offer_item(OP_TICK, pick_id(), pick_len());
    for (int i = 0; i < 16; i++)
      offer_item(OP_ARRIVE, ID_W'(i), LEN_W'($urandom_range(60, 20)));
    repeat (18) offer_item(OP_TICK, pick_id(), pick_len()); // level 2 full under level 1
    offer_item(OP_ARRIVE, ID_W'($urandom_range(15)), LEN_W'($urandom_range(60, 20)));
    offer_item(OP_TICK, pick_id(), pick_len());             // level 1 full under level 0
  endtask

  task automatic test_default_quanta_random();
    set_quanta(QUANTUM0_RESET, QUANTUM1_RESET);
    run_random_items(200, 55, -1);
  endtask

  task automatic test_zero_quanta();
    set_quanta(8'd0, 8'd0);
    run_random_items(150, 60, -1);
  endtask

  task automatic test_wide_quanta_no_idle();
    set_quanta(8'd255, 8'd255);
    src_stalls = 1'b0;
    sink_stalls <= 1'b0;
    run_random_items(150, 60, -1);
    src_stalls = 1'b1;
    sink_stalls <= 1'b1;
  endtask

  task automatic test_mid_quanta_with_drain();
    set_quanta(QNT_W'($urandom_range(10, 3)), QNT_W'($urandom_range(10, 3)));
    run_random_items(200, 55, 100);
  endtask

  task automatic test_mixed_quanta();
    set_quanta(8'd255, 8'd1);
    run_random_items(90, 65, -1);
    set_quanta(8'd1, 8'd255);
    run_random_items(90, 65, -1);
  endtask

  task automatic test_unit_quanta_heavy();
    set_quanta(8'd1, 8'd1);
    run_random_items(150, 45, -1);
  endtask

  initial begin
    for (int i = 0; i < 3; i++) begin
      fifo_head[i]  = 0;
      fifo_count[i] = 0;
    end
    for (int i = 0; i < ID_N; i++) begin
      work_left[i] = '0;
      live_refs[i] = 0;
    end
    level_used[0] = 0;
    level_used[1] = 0;
    quanta[REG_QUANTUM0] = QUANTUM0_RESET;
    quanta[REG_QUANTUM1] = QUANTUM1_RESET;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_basics();
    test_full_levels();
    test_default_quanta_random();
    test_unit_quanta_heavy();
    test_zero_quanta();
    test_wide_quanta_no_idle();
    test_mid_quanta_with_drain();
    test_mixed_quanta();

    wait_for_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && reports_due.size() == 0) begin
      $display("tb_three_level_feedback_queue_scheduler_core: PASS");
    end else begin
      $display("tb_three_level_feedback_queue_scheduler_core: FAIL");
    end
    $finish;
  end

endmodule
